[rtl/core/apu_pkg.sv]
// Shared constants and widths for the Adam parameter update block.
`default_nettype none
package apu_pkg;
  localparam int PARAM_DEPTH = 1024;
  localparam int IDX_W       = $clog2(PARAM_DEPTH);
  localparam int MOM_W       = 80;  // {v (48), m (32)}
  localparam int IN_W        = 112;

  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
  localparam logic [47:0] MASK48  = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] CFG_LEARN_RATE   = 2'd0;
  localparam logic [1:0] CFG_DECAY_FIRST  = 2'd1;
  localparam logic [1:0] CFG_DECAY_SECOND = 2'd2;
  localparam logic [1:0] CFG_EPSILON      = 2'd3;
endpackage
`default_nettype wire

[rtl/core/apu_pow.sv]
// Square-and-multiply unit: 2^32 - beta^t in Q0.32, one exponent bit per cycle.
`default_nettype none
module apu_pow import apu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [16:0] beta,
  input  wire logic [31:0] step,
  output logic             done,
  output logic [32:0]      denom
);
  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [31:0] base_r;
  logic [32:0] acc_r;
  logic [31:0] t_r;
  logic        unity_r;
  logic [64:0] acc_prod;
  logic [63:0] base_prod;

  assign acc_prod  = acc_r * base_r;
  assign base_prod = base_r * base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      base_r  <= {beta[15:0], 16'h0000};
      acc_r   <= ONE_Q32;
      t_r     <= step;
      unity_r <= (beta >= ONE_Q16);
    end else if (busy_r) begin
      if (t_r[0]) acc_r <= acc_prod[64:32];
      base_r <= base_prod[63:32];
      t_r    <= {1'b0, t_r[31:1]};
    end
  end

  assign done  = done_r;
  assign denom = unity_r ? 33'd0 : ONE_Q32 - acc_r;
endmodule
`default_nettype wire

[rtl/core/apu_div.sv]
// Restoring divider, (hi*2^64 + lo) / d, one quotient bit per cycle, saturating.
`default_nettype none
module apu_div import apu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] num_hi,
  input  wire logic [63:0] num_lo,
  input  wire logic [63:0] divisor,
  output logic             done,
  output logic [63:0]      quot
);
  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] rem_r;
  logic [63:0] lo_r;
  logic [63:0] d_r;
  logic [63:0] q_r;
  logic [63:0] shifted;
  logic        take;

  assign shifted = {rem_r[62:0], lo_r[63]};
  assign take    = rem_r[63] || (shifted >= d_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= '0;
        if (num_hi >= divisor) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num_hi;
      lo_r  <= num_lo;
      d_r   <= divisor;
      q_r   <= (num_hi >= divisor) ? {64{1'b1}} : 64'd0;
    end else if (busy_r) begin
      rem_r <= take ? shifted - d_r : shifted;
      lo_r  <= {lo_r[62:0], 1'b0};
      q_r   <= {q_r[62:0], take};
    end
  end

  assign done = done_r;
  assign quot = q_r;
endmodule
`default_nettype wire

[rtl/core/adam_parameter_update.sv]
// Adam optimizer step for one parameter per transaction, moments in on-chip memory.
// After reset the block sweeps its 1024-entry moment memory to zero, one entry a
// cycle, and holds in_tready low during the sweep; configuration writes are
// taken at any time. Items are handled one at a time, paced by the shared 64-step
// divider (used up to three times per item; a divide that saturates skips its
// steps), the 32-step power unit (run once per decay weight) and the 32-step square
// root. A zero time step or a decay weight of one or more returns the value unchanged
// with update_error set. A stalled receiver holds the block in S_FIN until the output
// register frees up. in_tready rises again in the cycle after the result is
// registered. The moment entry is read on acceptance and written back before the
// next item is taken.
`default_nettype none
module adam_parameter_update import apu_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  // param_index[9:0], param_value[41:10], gradient[73:42], step_number[105:74]
  input  wire logic [IN_W-1:0] in_tdata,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  // new_value[31:0]
  output logic [31:0]          out_tdata,
  // update_error[0]
  output logic                 out_tuser,
  input  wire logic            cfg_wr_en,
  input  wire logic [1:0]      cfg_addr,
  input  wire logic [31:0]     cfg_wr_data
);
  typedef enum logic [15:0] {
    S_CLR  = 16'h0001, S_IDLE = 16'h0002, S_RD   = 16'h0004, S_MOM  = 16'h0008,
    S_WB   = 16'h0010, S_POW1 = 16'h0020, S_POW2 = 16'h0040, S_CHK  = 16'h0080,
    S_DIVM = 16'h0100, S_DIVV = 16'h0200, S_SQRT = 16'h0400, S_MUL0 = 16'h0800,
    S_MUL1 = 16'h1000, S_CST  = 16'h2000, S_DIVC = 16'h4000, S_FIN  = 16'h8000
  } state_t;

  state_t state_r;

  logic [23:0] learn_rate_r;
  logic [16:0] decay_first_r;
  logic [16:0] decay_second_r;
  logic [31:0] epsilon_r;

  logic [MOM_W-1:0] mem_r [PARAM_DEPTH];
  logic [MOM_W-1:0] rdata_r;
  logic [IDX_W:0]   clr_cnt_r;

  logic [IDX_W-1:0]   idx_r;
  logic signed [31:0] param_r;
  logic signed [31:0] grad_r;
  logic [31:0]        step_r;

  logic signed [49:0] prod_a_r;
  logic signed [49:0] prod_b_r;
  logic [63:0]        gsq_r;
  logic [47:0]        v_old_r;
  logic [31:0]        m_new_r;
  logic [64:0]        tv_r;
  logic [64:0]        uv_r;
  logic [32:0]        d1_r;
  logic [32:0]        d2_r;
  logic [47:0]        mh_r;
  logic               neg_r;
  logic [63:0]        sq_x_r;
  logic [63:0]        sq_res_r;
  logic [63:0]        sq_bit_r;
  logic [4:0]         it_cnt_r;
  logic [40:0]        den_r;
  logic [71:0]        prod_r;
  logic [63:0]        corr_q_r;
  logic               res_pend_r;
  logic [31:0]        res_val_r;
  logic               res_err_r;

  logic               out_valid_r;
  logic [31:0]        out_data_r;
  logic               out_err_r;

  logic [16:0] b1c;
  logic [16:0] b2c;
  logic        accept;
  logic [31:0] g_mag;
  logic [31:0] m_abs;
  logic [50:0] s_sum;
  logic [65:0] v_sum;
  logic [47:0] v_new;
  logic [63:0] sq_sum;
  logic        out_free;

  logic        pow_start;
  logic        pow_done;
  logic [16:0] pow_beta;
  logic [32:0] pow_d;
  logic        div_start;
  logic        div_done;
  logic [63:0] div_hi;
  logic [63:0] div_lo;
  logic [63:0] div_d;
  logic [63:0] div_q;

  assign b1c = (decay_first_r > ONE_Q16) ? ONE_Q16 : decay_first_r;
  assign b2c = (decay_second_r > ONE_Q16) ? ONE_Q16 : decay_second_r;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  assign g_mag  = grad_r[31] ? 32'd0 - grad_r : grad_r;
  assign m_abs  = m_new_r[31] ? 32'd0 - m_new_r : m_new_r;
  assign s_sum  = {prod_a_r[49], prod_a_r} + {prod_b_r[49], prod_b_r};
  assign v_sum  = {1'b0, tv_r} + {1'b0, uv_r};
  assign v_new  = (b2c >= ONE_Q16) ? v_old_r : v_sum[63:16];
  assign sq_sum = sq_res_r + sq_bit_r;
  assign out_free = !out_valid_r || out_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_rate_r   <= 24'd16777;
      decay_first_r  <= 17'd58982;
      decay_second_r <= 17'd65470;
      epsilon_r      <= 32'd43;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_LEARN_RATE:   learn_rate_r   <= cfg_wr_data[23:0];
        CFG_DECAY_FIRST:  decay_first_r  <= cfg_wr_data[16:0];
        CFG_DECAY_SECOND: decay_second_r <= cfg_wr_data[16:0];
        CFG_EPSILON:      epsilon_r      <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // moment memory: clear sweep after reset, write back in S_WB
  always_ff @(posedge clk) begin
    if (state_r == S_CLR) begin
      mem_r[clr_cnt_r[IDX_W-1:0]] <= '0;
    end else if (state_r == S_WB) begin
      mem_r[idx_r] <= {v_new, m_new_r};
    end
    if (accept) rdata_r <= mem_r[in_tdata[IDX_W-1:0]];
  end

  // shared unit control
  assign pow_start = (state_r == S_WB) || ((state_r == S_POW1) && pow_done);
  assign pow_beta  = (state_r == S_WB) ? b1c : b2c;

  always_comb begin
    div_start = 1'b0;
    div_hi    = 64'd0;
    div_lo    = {m_abs, 32'd0};
    div_d     = {31'd0, d1_r};
    case (state_r)
      S_CHK: begin
        div_start = (d1_r != 33'd0) && (d2_r != 33'd0);
      end
      S_DIVM: begin
        div_start = div_done;
        div_hi    = {48'd0, v_new[47:32]};
        div_lo    = {v_new[31:0], 32'd0};
        div_d     = {31'd0, d2_r};
      end
      S_CST: begin
        div_start = (den_r != 41'd0);
        div_hi    = {48'd0, prod_r[71:56]};
        div_lo    = {prod_r[55:0], 8'd0};
        div_d     = {23'd0, den_r};
      end
      default: ;
    endcase
  end

  apu_pow u_pow (
    .clk   (clk),
    .rst_n (rst_n),
    .start (pow_start),
    .beta  (pow_beta),
    .step  (step_r),
    .done  (pow_done),
    .denom (pow_d)
  );

  apu_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num_hi  (div_hi),
    .num_lo  (div_lo),
    .divisor (div_d),
    .done    (div_done),
    .quot    (div_q)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_cnt_r  <= '0;
      res_pend_r <= 1'b0;
    end else begin
      case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == (IDX_W + 1)'(PARAM_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (accept) state_r <= S_RD;
        S_RD:   state_r <= S_MOM;
        S_MOM:  state_r <= S_WB;
        S_WB:   state_r <= S_POW1;
        S_POW1: if (pow_done) state_r <= S_POW2;
        S_POW2: if (pow_done) state_r <= S_CHK;
        S_CHK: begin
          if (d1_r == 33'd0 || d2_r == 33'd0) begin
            res_pend_r <= 1'b1;
            state_r    <= S_FIN;
          end else begin
            state_r <= S_DIVM;
          end
        end
        S_DIVM: if (div_done) state_r <= S_DIVV;
        S_DIVV: if (div_done) state_r <= S_SQRT;
        S_SQRT: if (it_cnt_r == 5'd31) state_r <= S_MUL0;
        S_MUL0: state_r <= S_MUL1;
        S_MUL1: state_r <= S_CST;
        S_CST:  state_r <= (den_r == 41'd0) ? S_FIN : S_DIVC;
        S_DIVC: if (div_done) state_r <= S_FIN;
        S_FIN: begin
          // hold until the output register frees up
          if (out_free) begin
            res_pend_r <= 1'b0;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r   <= in_tdata[9:0];
      param_r <= in_tdata[41:10];
      grad_r  <= in_tdata[73:42];
      step_r  <= in_tdata[105:74];
    end
    case (state_r)
      S_RD: begin
        v_old_r  <= rdata_r[79:32];
        prod_a_r <= $signed({1'b0, b1c}) * $signed(rdata_r[31:0]);
        prod_b_r <= $signed({1'b0, ONE_Q16 - b1c}) * grad_r;
        gsq_r    <= g_mag * g_mag;
      end
      S_MOM: begin
        m_new_r <= s_sum[47:16];
        tv_r    <= b2c * v_old_r;
        uv_r    <= (ONE_Q16 - b2c) * gsq_r[63:16];
      end
      S_WB: begin
        v_old_r <= v_new;
      end
      S_POW1: if (pow_done) d1_r <= pow_d;
      S_POW2: if (pow_done) d2_r <= pow_d;
      S_CHK: begin
        neg_r     <= m_new_r[31];
        res_val_r <= param_r;
        res_err_r <= 1'b1;
      end
      S_DIVM: if (div_done) mh_r <= (div_q > {16'd0, MASK48}) ? MASK48 : div_q[47:0];
      S_DIVV: begin
        if (div_done) begin
          sq_x_r   <= {((div_q > {16'd0, MASK48}) ? MASK48 : div_q[47:0]), 16'd0};
          sq_res_r <= 64'd0;
          sq_bit_r <= 64'h4000_0000_0000_0000;
          it_cnt_r <= 5'd0;
        end
      end
      S_SQRT: begin
        it_cnt_r <= it_cnt_r + 5'd1;
        if (sq_x_r >= sq_sum) begin
          sq_x_r   <= sq_x_r - sq_sum;
          sq_res_r <= {1'b0, sq_res_r[63:1]} + sq_bit_r;
        end else begin
          sq_res_r <= {1'b0, sq_res_r[63:1]};
        end
        sq_bit_r <= {2'b00, sq_bit_r[63:2]};
      end
      S_MUL0: begin
        den_r  <= {1'b0, sq_res_r[31:0], 8'd0} + {9'd0, epsilon_r};
        prod_r <= {24'd0, 48'(learn_rate_r) * 48'(mh_r[23:0])};
      end
      S_MUL1: begin
        prod_r <= prod_r + {48'(learn_rate_r) * 48'(mh_r[47:24]), 24'd0};
      end
      S_CST: begin
        // zero denominator: full scale unless the corrected moment is zero
        corr_q_r <= (mh_r == 48'd0) ? 64'd0 : {64{1'b1}};
        res_err_r <= 1'b0;
      end
      S_DIVC: if (div_done) corr_q_r <= div_q;
      default: ;
    endcase
  end

  // final correction and saturation
  logic [33:0]        corr_c;
  logic signed [35:0] res_wide;
  logic [31:0]        res_sat;

  always_comb begin
    corr_c   = (corr_q_r > 64'h2_0000_0000) ? 34'h2_0000_0000 : corr_q_r[33:0];
    res_wide = neg_r ? {{4{param_r[31]}}, param_r} + $signed({2'b00, corr_c})
                     : {{4{param_r[31]}}, param_r} - $signed({2'b00, corr_c});
    if (res_wide > 36'sd2147483647)       res_sat = 32'h7FFF_FFFF;
    else if (res_wide < -36'sd2147483648) res_sat = 32'h8000_0000;
    else                                  res_sat = res_wide[31:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (state_r == S_FIN && out_free) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_data_r <= res_pend_r ? res_val_r : res_sat;
      out_err_r  <= res_pend_r ? res_err_r : 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_err_r;
endmodule
`default_nettype wire

[tb/tb.sv]
// Testbench for adam_parameter_update: scoreboard with Adam-step predictor, directed and random stimulus.
`timescale 1ns / 1ps
module tb import apu_pkg::*;;

  typedef struct packed {
    logic [31:0] value;
    logic        err;
  } update_t;

  class update_scoreboard;
    logic [31:0] first_mom[PARAM_DEPTH];
    logic [47:0] second_mom[PARAM_DEPTH];
    logic [23:0] learn_rate;
    logic [16:0] decay_first;
    logic [16:0] decay_second;
    logic [31:0] epsilon;
    update_t     expected_updates[$];
    int          mismatches;
    int          items_seen;
    int          updates_checked;
    int          errors_flagged;

    function new();
      foreach (first_mom[i]) begin
        first_mom[i] = '0;
        second_mom[i] = '0;
      end
      learn_rate = 24'd16777;
      decay_first = 17'd58982;
      decay_second = 17'd65470;
      epsilon = 32'd43;
    endfunction

    function void write_reg(logic [1:0] addr, logic [31:0] data);
      case (addr)
        CFG_LEARN_RATE: begin
          learn_rate = data[23:0];
        end
        CFG_DECAY_FIRST: begin
          decay_first = data[16:0];
        end
        CFG_DECAY_SECOND: begin
          decay_second = data[16:0];
        end
        default: begin
          epsilon = data;
        end
      endcase
    endfunction

    // 2^32 - beta^t in Q0.32, by square-and-multiply
    function logic [127:0] bias_denom(logic [16:0] beta, logic [31:0] t);
      logic [127:0] base, acc;
      if (beta >= ONE_Q16) return '0;
      base = 128'(beta) << 16;
      acc = 128'h1 << 32;
      for (int i = 0; i < 32; i++) begin
        if (t[i]) acc = (acc * base) >> 32;
        base = (base * base) >> 32;
      end
      return (128'h1 << 32) - acc;
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] res, bw;
      res = '0;
      bw = 64'h1 << 62;
      while (bw > x) bw = bw >> 2;
      while (bw != 0) begin
        if (x >= res + bw) begin
          x = x - (res + bw);
          res = (res >> 1) + bw;
        end else begin
          res = res >> 1;
        end
        bw = bw >> 2;
      end
      return res;
    endfunction

    function void note_input(logic [9:0] idx, logic [31:0] p, logic [31:0] g,
                             logic [31:0] t);
      logic signed [63:0] m_old, g_s, b1s, s, m_new, res;
      logic [16:0]        b1, b2;
      logic [63:0]        gm, g2, mabs;
      logic [127:0]       v, d1, d2, mh, vh, den, prod, q;
      update_t            u;
      b1 = (decay_first > ONE_Q16) ? ONE_Q16 : decay_first;
      b2 = (decay_second > ONE_Q16) ? ONE_Q16 : decay_second;
      m_old = {{32{first_mom[idx][31]}}, first_mom[idx]};
      g_s = {{32{g[31]}}, g};
      b1s = 64'(b1);
      s = b1s * m_old + (64'sd65536 - b1s) * g_s;
      m_new = s >>> 16;
      first_mom[idx] = m_new[31:0];
      gm = g_s < 0 ? -g_s : g_s;
      g2 = (gm * gm) >> 16;
      v = 128'(second_mom[idx]);
      if (b2 < ONE_Q16) v = (128'(b2) * v + 128'(ONE_Q16 - b2) * 128'(g2)) >> 16;
      v = v & 128'(MASK48);
      second_mom[idx] = v[47:0];
      items_seen++;
      d1 = bias_denom(b1, t);
      d2 = bias_denom(b2, t);
      if (d1 == 0 || d2 == 0) begin
        u.value = p;
        u.err = 1'b1;
        expected_updates.push_back(u);
        return;
      end
      mabs = m_new < 0 ? -m_new : m_new;
      mh = (128'(mabs) << 32) / d1;
      if (mh > 128'(MASK48)) mh = 128'(MASK48);
      vh = (v << 32) / d2;
      if (vh > 128'(MASK48)) vh = 128'(MASK48);
      den = (128'(int_sqrt(vh[63:0] << 16)) << 8) + 128'(epsilon);
      prod = (128'(learn_rate) * mh) << 8;
      if (den == 0) q = (mh == 0) ? '0 : (128'h1 << 33);
      else q = prod / den;
      if (q > (128'h1 << 33)) q = 128'h1 << 33;
      res = {{32{p[31]}}, p};
      res = (m_new < 0) ? res + 64'(q) : res - 64'(q);
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      u.value = res[31:0];
      u.err = 1'b0;
      expected_updates.push_back(u);
    endfunction

    function void check_result(logic [31:0] value, logic err);
      update_t u;
      if (expected_updates.size() == 0) begin
        $error("unexpected result: new_value %0d update_error %0d", $signed(value), err);
        mismatches++;
        return;
      end
      u = expected_updates.pop_front();
      updates_checked++;
      if (u.err) errors_flagged++;
      if (value !== u.value) begin
        $error("new_value: expected %0d actual %0d", $signed(u.value), $signed(value));
        mismatches++;
      end
      if (err !== u.err) begin
        $error("update_error: expected %0d actual %0d", u.err, err);
        mismatches++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE = 400;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [31:0]  out_tdata;
  logic         out_tuser;
  logic         cfg_wr_en;
  logic [1:0]   cfg_addr;
  logic [31:0]  cfg_wr_data;

  update_scoreboard sb;
  int               cycles;
  bit               quiet;       // no idling on either side
  bit               hold_out;    // long receiver hold-off requested
  int               phases;
  logic [31:0]      step_of[16];

  adam_parameter_update u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  // receiver: ready bursts, idle bursts, and one long hold-off on request
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_out) begin
        @(negedge clk) out_tready <= 1'b0;
        repeat (3000) @(negedge clk);
        hold_out = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        @(negedge clk) out_tready <= 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end else begin
        @(negedge clk) out_tready <= 1'b1;
        repeat ($urandom_range(0, 31)) @(negedge clk);
      end
    end
  end

  task automatic write_cfg(logic [1:0] addr, logic [31:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= addr;
    cfg_wr_data <= data;
    sb.write_reg(addr, data);
    @(negedge clk) cfg_wr_en <= 1'b0;
  endtask

  // drop the offer first so the block takes nothing while it empties
  task automatic drain();
    @(negedge clk) in_tvalid <= 1'b0;
    while (sb.expected_updates.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_optimizer(logic [23:0] lr, logic [16:0] b1, logic [16:0] b2,
                               logic [31:0] eps);
    drain();
    write_cfg(CFG_LEARN_RATE, 32'(lr));
    write_cfg(CFG_DECAY_FIRST, 32'(b1));
    write_cfg(CFG_DECAY_SECOND, 32'(b2));
    write_cfg(CFG_EPSILON, eps);
    phases++;
  endtask

  task automatic send_item(logic [9:0] idx, logic [31:0] p, logic [31:0] g, logic [31:0] t);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 15)) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, t, g, p, idx};
    do @(posedge clk); while (!in_tready);
    sb.note_input(idx, p, g, t);
  endtask

  task automatic random_item();
    logic [3:0]  k;
    logic [31:0] g;
    if ($urandom_range(0, 4) == 0) begin
      send_item(10'($urandom), $urandom, $urandom, $urandom_range(0, 7) == 0 ? 32'd0 : $urandom);
    end else begin
      // training-like sequence on 16 slots with step numbers that rise and sometimes restart at one
      k = 4'($urandom);
      g = 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000) >>> $urandom_range(0, 8);
      if ($urandom_range(0, 9) == 0) step_of[k] = 32'd1;
      else step_of[k] = step_of[k] + 1;
      send_item({6'(k * 61), k}, 32'($signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000),
                g, step_of[k]);
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    quiet = 1'b0;
    hold_out = 1'b0;
    phases = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_wr_en = 1'b0;
    cfg_addr = CFG_LEARN_RATE;
    cfg_wr_data = '0;
    foreach (step_of[i]) step_of[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: default settings, field extremes, zero step
    send_item(10'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1);
    send_item(10'd1023, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(10'd0, 32'h0100_0000, 32'h8000_0000, 32'd2);
    send_item(10'd1023, 32'hFF00_0000, 32'h7FFF_FFFF, 32'd0);
    send_item(10'd5, 32'd0, 32'd0, 32'd1);
    send_item(10'd6, 32'h0123_4567, 32'hFFFF_0000, 32'd3);

    // zero decay, zero epsilon: zero denominator with and without a first moment
    set_optimizer(24'hFF_FFFF, 17'd0, 17'd0, 32'd0);
    send_item(10'd100, 32'h0100_0000, 32'd0, 32'd1);
    send_item(10'd101, 32'h0100_0000, 32'd100, 32'd1);
    send_item(10'd102, 32'hFF00_0000, 32'hFFFF_FF9C, 32'd1);
    send_item(10'd103, 32'h7FFF_0000, 32'h0100_0000, 32'd7);

    // unit decay: error on every item
    set_optimizer(24'd1, 17'd65536, 17'd65535, 32'hFFFF_FFFF);
    send_item(10'd7, 32'h1234_5678, 32'h0001_0000, 32'd9);
    send_item(10'd8, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);

    // decay above one acts as one
    set_optimizer(24'd167772, 17'h1FFFF, 17'd58982, 32'd1000);
    send_item(10'd9, 32'h0000_0001, 32'h0200_0000, 32'd4);
    send_item(10'd10, 32'h7FFF_FFFF, 32'hFE00_0000, 32'd5);
    set_optimizer(24'd1677721, 17'd45000, 17'h1FFFF, 32'd0);
    send_item(10'd11, 32'h0000_0000, 32'h0300_0000, 32'd6);
    send_item(10'd12, 32'h8000_0001, 32'h7FFF_FFFF, 32'd1);

    // random phases, each under its own setting
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_optimizer(24'd16777, 17'd58982, 17'd65470, 32'd43);
        3: set_optimizer(24'hFF_FFFF, 17'd65535, 17'd65535, 32'd0);
        5: set_optimizer(24'd1, 17'd1, 17'd1, 32'hFFFF_FFFF);
        default: set_optimizer(24'($urandom_range(1, 24'hFF_FFFF)),
                               17'($urandom_range(32768, 65536)),
                               17'($urandom_range(60000, 65536)),
                               $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4096));
      endcase
      if (ph == 7) quiet = 1'b1;
      for (int n = 0; n < 210; n++) begin
        if (ph == 2 && n == 20) hold_out = 1'b1;
        if (ph == 4 && n == 50) begin
          @(negedge clk) in_tvalid <= 1'b0;
          while (sb.expected_updates.size() != 0) @(posedge clk);
          repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        random_item();
      end
    end

    drain();
    $display("Covered %0d items over %0d optimizer settings; %0d results checked, %0d flagged.",
             sb.items_seen, phases, sb.updates_checked, sb.errors_flagged);
    if (sb.mismatches == 0 && sb.expected_updates.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/core/apu_pkg.sv
rtl/core/apu_pow.sv
rtl/core/apu_div.sv
rtl/core/adam_parameter_update.sv
tb/tb.sv
